// ===== hdl/frp_pkg.sv =====
// Shared types, constants and sector layout functions for the erase range planner.
package frp_pkg;

	localparam int NUM_SECTORS = 24;
	localparam int SECTOR_W    = 5;
	localparam int ADDR_W      = 32;
	localparam int LEN_W       = 22;
	localparam int BYTES_W     = 18;
	localparam int STATUS_W    = 2;
	localparam int BANK_AW     = 20;
	localparam int OFS_W       = BANK_AW + 1;
	localparam int END_W       = LEN_W + 1;
	localparam int BANK_SECT   = 12;
	localparam int Q_DEPTH     = 2;
	localparam int Q_AW        = 1;

	localparam logic [BYTES_W-1:0] SEC_SMALL = BYTES_W'(16 * 1024);
	localparam logic [BYTES_W-1:0] SEC_MID   = BYTES_W'(64 * 1024);
	localparam logic [BYTES_W-1:0] SEC_BIG   = BYTES_W'(128 * 1024);

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PAST  = 2'd2;

	typedef struct packed {
		logic                  err;
		logic [STATUS_W-1:0]   status;
		logic [SECTOR_W-1:0]   first;
		logic [SECTOR_W-1:0]   final_sec;
	} frp_cmd_t;

	function automatic logic [3:0] local_index(input logic [SECTOR_W-1:0] s);
		logic [SECTOR_W-1:0] l;
		l = (s >= SECTOR_W'(BANK_SECT)) ? s - SECTOR_W'(BANK_SECT) : s;
		return l[3:0];
	endfunction

	function automatic logic [BYTES_W-1:0] sec_size(input logic [SECTOR_W-1:0] s);
		logic [3:0] l;
		l = local_index(s);
		if (l < 4'd4) begin
			return SEC_SMALL;
		end else if (l == 4'd4) begin
			return SEC_MID;
		end else begin
			return SEC_BIG;
		end
	endfunction

	function automatic logic [ADDR_W-1:0] sec_offset(input logic [SECTOR_W-1:0] s);
		logic [3:0]        l;
		logic [ADDR_W-1:0] o;
		l = local_index(s);
		if (l < 4'd4) begin
			o = ADDR_W'(l) << 14;
		end else begin
			o = ADDR_W'(l - 4'd4) << 17;
			if (l == 4'd4) begin
				o = ADDR_W'(SEC_MID);
			end
		end
		if (s >= SECTOR_W'(BANK_SECT)) begin
			o = o + (ADDR_W'(1) << BANK_AW);
		end
		return o;
	endfunction

	function automatic logic [SECTOR_W-1:0] sector_of(input logic [OFS_W-1:0] o);
		logic [BANK_AW-1:0]  l;
		logic [SECTOR_W-1:0] loc;
		l = o[BANK_AW-1:0];
		if (l < BANK_AW'(64 * 1024)) begin
			loc = SECTOR_W'(l[15:14]);
		end else begin
			loc = SECTOR_W'(4) + SECTOR_W'(l[19:17]);
		end
		if (o[BANK_AW]) begin
			loc = loc + SECTOR_W'(BANK_SECT);
		end
		return loc;
	endfunction

	function automatic logic [ADDR_W-1:0] flash_total();
		logic [ADDR_W-1:0] t;
		t = '0;
		for (int i = 0; i < NUM_SECTORS; i++) begin
			t = t + ADDR_W'(sec_size(SECTOR_W'(i)));
		end
		return t;
	endfunction

	localparam logic [ADDR_W-1:0] FLASH_BYTES = flash_total();

endpackage

// ===== hdl/frp_front.sv =====
// Front part: takes requests, checks the range and works out the first and final sector.
module frp_front import frp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ADDR_W-1:0] base_addr,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ADDR_W-1:0] start_address,
	input  logic [LEN_W-1:0]  length,
	input  logic              q_full,
	output logic              q_push,
	output frp_cmd_t          q_cmd
);

	logic                vld_s1;
	logic [ADDR_W:0]     off_s1;
	logic [LEN_W-1:0]    len_s1;
	logic                len_zero;
	logic                take;
	logic [OFS_W-1:0]    off_lo;
	logic [END_W-1:0]    end_ofs;
	logic                past;
	logic [OFS_W-1:0]    last_byte;

	assign len_zero = (len_s1 == '0);
	assign take     = vld_s1 && (len_zero || !q_full);
	assign in_stall = vld_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!vld_s1 || take) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!vld_s1 || take) && in_valid) begin
			off_s1 <= {1'b0, start_address} - {1'b0, base_addr};
			len_s1 <= length;
		end
	end

	always_comb begin
		off_lo    = off_s1[OFS_W-1:0];
		end_ofs   = END_W'(off_lo) + END_W'(len_s1);
		past      = ADDR_W'(end_ofs) > FLASH_BYTES;
		last_byte = past ? OFS_W'(FLASH_BYTES - ADDR_W'(1)) : OFS_W'(end_ofs - END_W'(1));
		q_cmd.err = off_s1[ADDR_W] || (off_s1[ADDR_W-1:0] >= FLASH_BYTES);
		q_cmd.status    = past ? ST_PAST : ST_OK;
		q_cmd.first     = sector_of(off_lo);
		q_cmd.final_sec = sector_of(last_byte);
		q_push    = vld_s1 && !len_zero && !q_full;
	end

endmodule

// ===== hdl/frp_queue.sv =====
// Short command queue between the front and back parts.
module frp_queue import frp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  frp_cmd_t push_cmd,
	input  logic     pop,
	output frp_cmd_t head,
	output logic     full,
	output logic     empty
);

	frp_cmd_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     count_q;

	assign full  = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (Q_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (Q_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hdl/frp_back.sv =====
// Back part: walks from the first to the final sector of a command, one result beat a cycle unless out_stall holds.
module frp_back import frp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [ADDR_W-1:0]   base_addr,
	input  frp_cmd_t            head,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [SECTOR_W-1:0] sector,
	output logic [ADDR_W-1:0]   sector_start,
	output logic [BYTES_W-1:0]  sector_bytes,
	output logic [STATUS_W-1:0] status,
	output logic                last
);

	logic                busy_q;
	logic [SECTOR_W-1:0] cnt_q;
	logic                out_valid_q;
	logic [SECTOR_W-1:0] sector_q;
	logic [ADDR_W-1:0]   start_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic [STATUS_W-1:0] status_q;
	logic                last_q;
	logic                load;
	logic                fire;
	logic [SECTOR_W-1:0] cur;
	logic                is_last;

	assign load    = !out_valid_q || !out_stall;
	assign fire    = load && !q_empty;
	assign cur     = busy_q ? cnt_q : head.first;
	assign is_last = head.err || (cur == head.final_sec);
	assign q_pop   = fire && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
		end else if (load) begin
			out_valid_q <= fire;
			if (fire) begin
				busy_q <= !is_last;
				cnt_q  <= cur + SECTOR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (head.err) begin
				sector_q <= '0;
				start_q  <= '0;
				bytes_q  <= '0;
				status_q <= ST_RANGE;
				last_q   <= 1'b1;
			end else begin
				sector_q <= cur;
				start_q  <= base_addr + sec_offset(cur);
				bytes_q  <= sec_size(cur);
				status_q <= head.status;
				last_q   <= is_last;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign sector       = sector_q;
	assign sector_start = start_q;
	assign sector_bytes = bytes_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule

// ===== hdl/flash_erase_range_planner_core.sv =====
// Top level of the flash erase range planner: base register, front, queue and back.
//
//  Channel   Handshake            Beat
//  in        in_valid/in_stall    start_address, length
//  out       out_valid/out_stall  sector, sector_start, sector_bytes, status, last
//  config    cfg_we               cfg_wdata (flash base address)
//
// A request is held in the front register, then waits in a two-entry queue.
// The back part emits one sector beat a cycle while out_stall is low, one beat for each
// sector a request covers (at most 24); zero-length requests leave no trace after the front.
// Reset is asynchronous and clears all control state; the base returns to 0x08000000.
// A stalled output holds the back part only; the front keeps accepting until the queue fills.
module flash_erase_range_planner_core import frp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [ADDR_W-1:0]   cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [ADDR_W-1:0]   start_address,
	input  logic [LEN_W-1:0]    length,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [SECTOR_W-1:0] sector,
	output logic [ADDR_W-1:0]   sector_start,
	output logic [BYTES_W-1:0]  sector_bytes,
	output logic [STATUS_W-1:0] status,
	output logic                last
);

	logic [ADDR_W-1:0] base_addr_q;
	logic              q_full;
	logic              q_empty;
	logic              q_push;
	logic              q_pop;
	frp_cmd_t          q_cmd;
	frp_cmd_t          q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addr_q <= 32'h0800_0000;
		end else if (cfg_we) begin
			base_addr_q <= cfg_wdata;
		end
	end

	frp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.base_addr     (base_addr_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.start_address (start_address),
		.length        (length),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_cmd)
	);

	frp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	frp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.base_addr    (base_addr_q),
		.head         (q_head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sector       (sector),
		.sector_start (sector_start),
		.sector_bytes (sector_bytes),
		.status       (status),
		.last         (last)
	);

endmodule
